// ----- sv/stack_machine_execute_core_assert.svh -----
// assertion macros shared by the stack machine execute core rtl
// needs a clock and an active-low reset name at each use
`ifndef STACK_MACHINE_EXECUTE_CORE_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_CORE_ASSERT_SVH

// same-cycle implication
`define SMX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smx assertion failed");

// next-cycle implication
`define SMX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smx assertion failed");

`endif

// ----- sv/smx_pkg.sv -----
// types and constants for the stack machine execute core
// no dependencies
`default_nettype none

package smx_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int DIV_STEPS   = WORD_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef enum logic [4:0] {
    OP_PUSH  = 5'd0,
    OP_POP   = 5'd1,
    OP_ADD   = 5'd2,
    OP_SUB   = 5'd3,
    OP_MUL   = 5'd4,
    OP_DIV   = 5'd5,
    OP_PRINT = 5'd6,
    OP_AND   = 5'd7,
    OP_OR    = 5'd8,
    OP_XOR   = 5'd9,
    OP_SHL   = 5'd10,
    OP_SHR   = 5'd11,
    OP_CMP   = 5'd12,
    OP_JMP   = 5'd13,
    OP_DUP   = 5'd14,
    OP_JE    = 5'd15,
    OP_JNE   = 5'd16
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_UNDER = 2'd1,
    STATUS_OVER  = 2'd2,
    STATUS_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              en;
    logic [PTR_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr_a;
    logic [PTR_W-1:0] addr_b;
  } ram_rd_t;

endpackage

`default_nettype wire

// ----- sv/smx_stack_ram.sv -----
// operand stack storage: one write port, two registered read ports
// depends on smx_pkg
`default_nettype none

module smx_stack_ram (
  input  logic                        clk_i,
  input  smx_pkg::ram_wr_t            wr_i,
  input  smx_pkg::ram_rd_t            rd_i,
  output logic [smx_pkg::WORD_W-1:0]  rd_a_o,
  output logic [smx_pkg::WORD_W-1:0]  rd_b_o
);

  logic [smx_pkg::WORD_W-1:0] mem [smx_pkg::STACK_DEPTH];
  logic [smx_pkg::WORD_W-1:0] rd_a_q;
  logic [smx_pkg::WORD_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_a_q <= mem[rd_i.addr_a];
      rd_b_q <= mem[rd_i.addr_b];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

`default_nettype wire

// ----- sv/smx_alu.sv -----
// combinational two-operand operations (everything but divide)
// depends on smx_pkg
`default_nettype none

module smx_alu (
  input  smx_pkg::op_e                op_i,
  input  logic [smx_pkg::WORD_W-1:0]  a_i,
  input  logic [smx_pkg::WORD_W-1:0]  b_i,
  output logic [smx_pkg::WORD_W-1:0]  r_o
);

  logic [4:0] sh;

  assign sh = a_i[4:0];

  always_comb begin
    case (op_i)
      smx_pkg::OP_ADD: r_o = b_i + a_i;
      smx_pkg::OP_SUB: r_o = b_i - a_i;
      smx_pkg::OP_MUL: r_o = b_i * a_i;
      smx_pkg::OP_AND: r_o = b_i & a_i;
      smx_pkg::OP_OR:  r_o = b_i | a_i;
      smx_pkg::OP_XOR: r_o = b_i ^ a_i;
      smx_pkg::OP_SHL: r_o = b_i << sh;
      smx_pkg::OP_SHR: r_o = $unsigned($signed(b_i) >>> sh);
      smx_pkg::OP_CMP: r_o = {{(smx_pkg::WORD_W-1){1'b0}}, (a_i == b_i)};
      default:         r_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/smx_div.sv -----
// signed 32-bit divider, restoring, one quotient bit per cycle
// truncates toward zero; depends on smx_pkg
`default_nettype none

module smx_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [smx_pkg::WORD_W-1:0]  num_i,
  input  logic [smx_pkg::WORD_W-1:0]  den_i,
  output logic                        done_o,
  output logic [smx_pkg::WORD_W-1:0]  quot_o
);

  localparam int W = smx_pkg::WORD_W;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [smx_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]                  rem_q, rem_d;
  logic [W-1:0]                  quot_q, quot_d;
  logic [W-1:0]                  den_q, den_d;
  logic                          neg_q, neg_d;
  logic [W:0]                    rem_sh;
  logic [W+1:0]                  diff;
  logic                          ge;

  assign rem_sh = {rem_q, quot_q[W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = !diff[W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quot_d = num_i[W-1] ? (~num_i + 1'b1) : num_i;
      den_d  = den_i[W-1] ? (~den_i + 1'b1) : den_i;
      neg_d  = num_i[W-1] ^ den_i[W-1];
    end else if (busy_q) begin
      rem_d  = ge ? diff[W-1:0] : rem_sh[W-1:0];
      quot_d = {quot_q[W-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == smx_pkg::DIV_CNT_W'(smx_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~quot_q + 1'b1) : quot_q;

endmodule

`default_nettype wire

// ----- sv/stack_machine_execute_core.sv -----
// stack machine execute core: one instruction per input item, one result per item
// depends on smx_pkg, smx_stack_ram, smx_alu, smx_div and the assertion macros
//
// input channel: func_i and immediate_i, taken when in_valid_i is high and
// in_stall_o is low. output channel: print, jump and status fields, taken when
// out_valid_o is high and out_stall_i is low.
// one item is worked on at a time. the stack words sit in a 256-entry ram with
// registered reads; the top two words are read on accept, the result is written
// back before the next item is taken.
// the result passes through the EXEC and DONE states into the output register;
// div also waits in the DIV state for the quotient of a 32-step bit-serial divider.
// the output register lets the next item be accepted while a result waits;
// when the receiver stalls, a finished item holds in its final step until the
// output register frees up, and the input then stalls.
// reset empties the stack; ram contents are left as they are.
`default_nettype none

module stack_machine_execute_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [4:0]         func_i,
  input  logic signed [31:0] immediate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               print_valid_o,
  output logic signed [31:0] print_value_o,
  output logic               jump_taken_o,
  output logic signed [31:0] jump_distance_o,
  output logic [1:0]         status_o
);

`include "stack_machine_execute_core_assert.svh"

  localparam int W = smx_pkg::WORD_W;

  smx_pkg::state_e            state_q, state_d;
  logic [smx_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  smx_pkg::op_e               op_q;
  logic [W-1:0]               imm_q;

  smx_pkg::ram_wr_t           wr_q, wr_d;
  logic [smx_pkg::CNT_W-1:0]  cnt_new_q, cnt_new_d;
  logic                       pv_q, pv_d;
  logic [W-1:0]               pval_q, pval_d;
  logic                       jt_q, jt_d;
  logic [W-1:0]               jd_q, jd_d;
  smx_pkg::status_e           st_q, st_d;

  logic                       out_valid_q, out_valid_d;
  logic                       out_pv_q;
  logic [W-1:0]               out_pval_q;
  logic                       out_jt_q;
  logic [W-1:0]               out_jd_q;
  logic [1:0]                 out_st_q;

  smx_pkg::ram_wr_t           ram_wr;
  smx_pkg::ram_rd_t           ram_rd;
  logic [W-1:0]               rd_a;
  logic [W-1:0]               rd_b;
  logic [W-1:0]               alu_r;
  logic                       div_start;
  logic                       div_done;
  logic [W-1:0]               div_quot;

  logic                       accept;
  logic                       out_free;
  logic                       load_out;
  logic                       has1;
  logic                       has2;
  logic                       full;
  logic [smx_pkg::CNT_W-1:0]  cnt_m1;
  logic [smx_pkg::CNT_W-1:0]  cnt_m2;
  logic [smx_pkg::CNT_W-1:0]  cnt_p1;

  assign in_stall_o = (state_q != smx_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cnt_m1 = cnt_q - smx_pkg::CNT_W'(1);
  assign cnt_m2 = cnt_q - smx_pkg::CNT_W'(2);
  assign cnt_p1 = cnt_q + smx_pkg::CNT_W'(1);
  assign has1   = (cnt_q != '0);
  assign has2   = (cnt_q > smx_pkg::CNT_W'(1));
  assign full   = (cnt_q == smx_pkg::CNT_W'(smx_pkg::STACK_DEPTH));

  assign ram_rd.en     = accept;
  assign ram_rd.addr_a = cnt_m1[smx_pkg::PTR_W-1:0];
  assign ram_rd.addr_b = cnt_m2[smx_pkg::PTR_W-1:0];

  smx_stack_ram u_ram (
    .clk_i  (clk_i),
    .wr_i   (ram_wr),
    .rd_i   (ram_rd),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  smx_alu u_alu (
    .op_i (op_q),
    .a_i  (rd_a),
    .b_i  (rd_b),
    .r_o  (alu_r)
  );

  smx_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rd_b),
    .den_i   (rd_a),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wr_d        = wr_q;
    cnt_new_d   = cnt_new_q;
    pv_d        = pv_q;
    pval_d      = pval_q;
    jt_d        = jt_q;
    jd_d        = jd_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start   = 1'b0;
    load_out    = 1'b0;
    ram_wr      = wr_q;
    ram_wr.en   = 1'b0;

    case (state_q)
      smx_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = smx_pkg::ST_EXEC;
        end
      end

      smx_pkg::ST_EXEC: begin
        wr_d      = '0;
        cnt_new_d = cnt_q;
        pv_d      = 1'b0;
        pval_d    = '0;
        jt_d      = 1'b0;
        jd_d      = '0;
        st_d      = smx_pkg::STATUS_OK;
        state_d   = smx_pkg::ST_DONE;
        case (op_q)
          smx_pkg::OP_PUSH: begin
            if (full) begin
              st_d = smx_pkg::STATUS_OVER;
            end else begin
              wr_d      = '{en: 1'b1, addr: cnt_q[smx_pkg::PTR_W-1:0], data: imm_q};
              cnt_new_d = cnt_p1;
            end
          end
          smx_pkg::OP_POP: begin
            if (!has1) begin
              st_d = smx_pkg::STATUS_UNDER;
            end else begin
              cnt_new_d = cnt_m1;
            end
          end
          smx_pkg::OP_PRINT: begin
            if (!has1) begin
              st_d = smx_pkg::STATUS_UNDER;
            end else begin
              cnt_new_d = cnt_m1;
              pv_d      = 1'b1;
              pval_d    = rd_a;
            end
          end
          smx_pkg::OP_JMP: begin
            jt_d = 1'b1;
            jd_d = imm_q;
          end
          smx_pkg::OP_DUP: begin
            if (!has1) begin
              st_d = smx_pkg::STATUS_UNDER;
            end else if (full) begin
              st_d = smx_pkg::STATUS_OVER;
            end else begin
              wr_d      = '{en: 1'b1, addr: cnt_q[smx_pkg::PTR_W-1:0], data: rd_a};
              cnt_new_d = cnt_p1;
            end
          end
          smx_pkg::OP_JE, smx_pkg::OP_JNE: begin
            if (!has1) begin
              st_d = smx_pkg::STATUS_UNDER;
            end else begin
              cnt_new_d = cnt_m1;
              if ((op_q == smx_pkg::OP_JE) == (rd_a != '0)) begin
                jt_d = 1'b1;
                jd_d = imm_q;
              end
            end
          end
          smx_pkg::OP_DIV: begin
            if (!has2) begin
              st_d = smx_pkg::STATUS_UNDER;
            end else if (rd_a == '0) begin
              st_d = smx_pkg::STATUS_DIVZ;
            end else begin
              div_start = 1'b1;
              wr_d      = '{en: 1'b1, addr: cnt_m2[smx_pkg::PTR_W-1:0], data: '0};
              cnt_new_d = cnt_m1;
              state_d   = smx_pkg::ST_DIV;
            end
          end
          smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_AND,
          smx_pkg::OP_OR, smx_pkg::OP_XOR, smx_pkg::OP_SHL, smx_pkg::OP_SHR,
          smx_pkg::OP_CMP: begin
            if (!has2) begin
              st_d = smx_pkg::STATUS_UNDER;
            end else begin
              wr_d      = '{en: 1'b1, addr: cnt_m2[smx_pkg::PTR_W-1:0], data: alu_r};
              cnt_new_d = cnt_m1;
            end
          end
          default: begin
          end
        endcase
      end

      smx_pkg::ST_DIV: begin
        if (div_done) begin
          wr_d.data = div_quot;
          state_d   = smx_pkg::ST_DONE;
        end
      end

      smx_pkg::ST_DONE: begin
        if (out_free) begin
          ram_wr      = wr_q;
          cnt_d       = cnt_new_q;
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = smx_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = smx_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smx_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= smx_pkg::op_e'(func_i);
      imm_q <= immediate_i;
    end
    wr_q      <= wr_d;
    cnt_new_q <= cnt_new_d;
    pv_q      <= pv_d;
    pval_q    <= pval_d;
    jt_q      <= jt_d;
    jd_q      <= jd_d;
    st_q      <= st_d;
    if (load_out) begin
      out_pv_q   <= pv_q;
      out_pval_q <= pval_q;
      out_jt_q   <= jt_q;
      out_jd_q   <= jd_q;
      out_st_q   <= st_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign print_valid_o   = out_pv_q;
  assign print_value_o   = out_pval_q;
  assign jump_taken_o    = out_jt_q;
  assign jump_distance_o = out_jd_q;
  assign status_o        = out_st_q;

  `SMX_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1,
                  cnt_q <= smx_pkg::CNT_W'(smx_pkg::STACK_DEPTH))
  `SMX_ASSERT_NXT(a_accept_exec, clk_i, rst_ni, accept, state_q == smx_pkg::ST_EXEC)
  `SMX_ASSERT_IMP(a_div_done_state, clk_i, rst_ni, div_done, state_q == smx_pkg::ST_DIV)
  `SMX_ASSERT_IMP(a_err_quiet, clk_i, rst_ni,
                  out_valid_o && (status_o != smx_pkg::STATUS_OK),
                  !print_valid_o && !jump_taken_o)
  `SMX_ASSERT_NXT(a_hold_out, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(status_o))

endmodule

`default_nettype wire
